// ===== rtl/core/g711du_pkg.sv =====
// ----------------------------------------------------------------------------
// G.711 decoder package
// Sample and code types, expansion constants and the mu-law / A-law
// expansion functions used by the decode and upsample block.
// ----------------------------------------------------------------------------
package g711du_pkg;

  typedef logic        [7:0]  code_t;
  typedef logic signed [15:0] pcm_t;

  // Codec select register values.
  localparam logic CODEC_MU_LAW = 1'b0;
  localparam logic CODEC_A_LAW  = 1'b1;

  localparam logic [15:0] MU_BIAS      = 16'h0084;
  localparam logic [15:0] A_SEG_OFFSET = 16'h0108;
  localparam logic [15:0] A_SEG0_HALF  = 16'd8;
  localparam logic [7:0]  A_TOGGLE     = 8'h55;

  // Mu-law expansion: the stored code is inverted, a set sign bit means negative.
  function automatic pcm_t expand_mu(code_t code);
    logic [7:0]  c;
    logic [2:0]  seg;
    logic [3:0]  mant;
    logic [15:0] mag;
    c    = ~code;
    seg  = c[6:4];
    mant = c[3:0];
    mag  = (({9'd0, mant, 3'd0} + MU_BIAS) << seg) - MU_BIAS;
    expand_mu = c[7] ? pcm_t'(16'd0 - mag) : pcm_t'(mag);
  endfunction

  // A-law expansion: even bits are toggled, a set sign bit means positive.
  function automatic pcm_t expand_a(code_t code);
    logic [7:0]  c;
    logic [2:0]  seg;
    logic [3:0]  mant;
    logic [15:0] mag;
    c    = code ^ A_TOGGLE;
    seg  = c[6:4];
    mant = c[3:0];
    if (seg == 3'd0) begin
      mag = {8'd0, mant, 4'd0} + A_SEG0_HALF;
    end else begin
      mag = ({8'd0, mant, 4'd0} + A_SEG_OFFSET) << (seg - 3'd1);
    end
    expand_a = c[7] ? pcm_t'(mag) : pcm_t'(16'd0 - mag);
  endfunction

endpackage

// ===== rtl/core/g711_decode_upsample_2x_top.sv =====
// ----------------------------------------------------------------------------
// G.711 decoder with 2x upsampling
// Decodes one mu-law or A-law code per input transaction into two 16-bit
// PCM samples: the midpoint against the previous sample, then the sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / code_byte) carries one G.711 code per
//   transaction. The output channel (out_valid / out_stall / pcm_sample /
//   last_of_pair) returns two transactions for each code: first the midpoint
//   of the previous and the current sample (truncated toward zero), with
//   last_of_pair low, then the current sample with last_of_pair high.
//   The configuration channel (cfg_valid / cfg_ready / codec_select) picks
//   mu-law (0) or A-law (1); it is always ready and should be written only
//   while the block is idle.
//   The midpoint passes through the pair buffer and then the output
//   register, and the current sample follows it through the same register.
//   The single output register sends one sample per cycle while out_stall is
//   low. A new code is accepted in the same cycle that the previous code's
//   second sample moves into the output register.
//   Reset clears both registers' valid flags, the previous sample (to zero)
//   and the codec select (to mu-law). A stall on the output holds the output
//   register and, once the pair buffer is full, raises in_stall.
// ----------------------------------------------------------------------------
module g711_decode_upsample_2x_top (
  input  logic               clk,
  input  logic               rst,
  // Configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               codec_select,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  g711du_pkg::code_t  code_byte,
  // Output channel
  output logic               out_valid,
  input  logic               out_stall,
  output g711du_pkg::pcm_t   pcm_sample,
  output logic               last_of_pair
);
  import g711du_pkg::*;

  // Configuration register.
  logic codec;

  // Last decoded sample, kept across items and codec changes.
  pcm_t prev_sample;

  // Pair buffer: the two results of one accepted code.
  logic pair_valid;
  logic pair_phase;   // 0: midpoint goes next, 1: current sample goes next
  pcm_t pair_mid;
  pcm_t pair_cur;

  logic in_accept;
  logic out_take;
  logic out_load;
  logic pair_done;

  pcm_t               cur_sample;
  logic signed [16:0] pair_sum;
  logic signed [16:0] pair_sum_adj;
  pcm_t               mid_sample;

  assign cfg_ready = 1'b1;

  // Decode and midpoint, straight from the input port into the pair buffer.
  always_comb begin
    cur_sample   = (codec == CODEC_A_LAW) ? expand_a(code_byte) : expand_mu(code_byte);
    pair_sum     = {prev_sample[15], prev_sample} + {cur_sample[15], cur_sample};
    // Adding one to a negative sum before the shift rounds toward zero.
    pair_sum_adj = pair_sum + {16'd0, pair_sum[16]};
    mid_sample   = pcm_t'(pair_sum_adj[16:1]);
  end

  // Handshakes. The output register loads whenever it is empty or being
  // drained; the pair buffer frees up as its second sample moves out.
  assign out_take  = out_valid && !out_stall;
  assign out_load  = pair_valid && (!out_valid || out_take);
  assign pair_done = out_load && pair_phase;
  assign in_stall  = pair_valid && !pair_done;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec <= CODEC_MU_LAW;
    end else if (cfg_valid && cfg_ready) begin
      codec <= codec_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      pair_valid  <= 1'b0;
      pair_phase  <= 1'b0;
    end else if (in_accept) begin
      prev_sample <= cur_sample;
      pair_valid  <= 1'b1;
      pair_phase  <= 1'b0;
    end else if (out_load) begin
      if (pair_phase) begin
        pair_valid <= 1'b0;
      end else begin
        pair_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pair_mid <= mid_sample;
      pair_cur <= cur_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pcm_sample   <= pair_phase ? pair_cur : pair_mid;
      last_of_pair <= pair_phase;
    end
  end

  // A new code never overwrites a pair whose midpoint has not been sent.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> !(pair_valid && !pair_phase))
    else $error("code accepted over a pending midpoint");

  // A midpoint that is taken is followed at once by its current sample.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_pair && !out_stall |=> out_valid && last_of_pair)
    else $error("midpoint not followed by its current sample");

  // The output register is only empty while the pair buffer is empty too
  // or was just filled.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair_phase |-> out_valid)
    else $error("pending current sample without an output midpoint");

endmodule
